// File: rtl/core/wmv_pkg.sv
// Shared widths, constants and payload types of the windowed motion variance block.
package wmv_pkg;

    // Field and datapath widths.
    localparam int unsigned AXIS_W = 16;
    localparam int unsigned MAG_W  = 16;
    localparam int unsigned MAG2_W = 2 * MAG_W;
    localparam int unsigned VAR_W  = 32;
    localparam int unsigned THR_W  = 32;

    // Default window depth for the top level.
    localparam int unsigned DEFAULT_WINDOW_DEPTH = 32;

    // Configuration port.
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_IDX_LSB = 2;
    localparam int unsigned CFG_IDX_W   = CFG_ADDR_W - CFG_IDX_LSB;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = '0;
    localparam logic [THR_W-1:0]     THRESHOLD_RESET      = 32'd10000;

    // Input transaction payload.
    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
    } t_sample;

    // Output transaction payload.
    typedef struct packed {
        logic [MAG_W-1:0] latest_magnitude;
        logic [MAG_W-1:0] mean_magnitude;
        logic [VAR_W-1:0] magnitude_variance;
        logic             motion;
    } t_result;

    // Handshake between the sequencer and one iterative unit.
    typedef struct packed {
        logic start;
        logic done;
    } t_unit_ctl;

endpackage

// File: rtl/core/wmv_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
interface wmv_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/wmv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module wmv_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/core/wmv_smul.sv
// Bit-serial unsigned multiplier: one multiplier bit per cycle, most significant first.
module wmv_smul #(
    parameter int unsigned W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [W-1:0]       i_a,
    input  logic [W-1:0]       i_b,
    output logic               o_done,
    output logic [2*W-1:0]     o_product
);
    localparam int unsigned CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [2*W-1:0]   r_acc;

    // Control: busy while the count runs down from W-1 to zero, then a single done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Shift-and-add datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[2*W-2:0], 1'b0} + (r_b[W-1] ? {{W{1'b0}}, r_a} : '0);
            r_b   <= {r_b[W-2:0], 1'b0};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;
endmodule

// File: rtl/core/wmv_isqrt.sv
// Digit-serial floor square root: two radicand bits per cycle, one root bit per cycle.
module wmv_isqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wmv_pkg::MAG2_W-1:0] i_value,
    output logic                      o_done,
    output logic [wmv_pkg::MAG_W-1:0] o_root,
    output logic [wmv_pkg::MAG_W+1:0] o_rem
);
    import wmv_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAG_W);
    localparam int unsigned REM_W = MAG_W + 2;
    localparam int unsigned SH_W  = MAG_W + 4;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [MAG2_W-1:0] r_val;
    logic [MAG_W-1:0]  r_root;
    logic [REM_W-1:0]  r_rem;
    logic [SH_W-1:0]   n_shifted;
    logic [SH_W-1:0]   n_trial;
    logic              n_take;

    // One root digit: bring down two bits and try to subtract 4q+1.
    always_comb begin
        n_shifted = {r_rem, r_val[MAG2_W-1 -: 2]};
        n_trial   = {2'b00, r_root, 2'b01};
        n_take    = (n_shifted >= n_trial);
    end

    // Control: MAG_W iterations, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Remainder and root registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[MAG2_W-3:0], 2'b00};
            if (n_take) begin
                r_rem  <= REM_W'(n_shifted - n_trial);
                r_root <= {r_root[MAG_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(n_shifted);
                r_root <= {r_root[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
    assign o_rem  = r_rem;
endmodule

// File: rtl/core/wmv_sdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle, most significant first.
module wmv_sdiv #(
    parameter int unsigned W = 21,
    parameter int unsigned D = 6
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [D-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);
    localparam int unsigned CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_q;
    logic [D-1:0]     r_dvs;
    logic [D-1:0]     r_rem;
    logic [D:0]       n_trial;
    logic             n_take;

    // Partial remainder with the next dividend bit brought down.
    always_comb begin
        n_trial = {r_rem, r_q[W-1]};
        n_take  = (n_trial >= {1'b0, r_dvs});
    end

    // Control: W iterations, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Dividend bits shift out at the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (n_take) begin
                r_rem <= D'(n_trial - {1'b0, r_dvs});
            end else begin
                r_rem <= D'(n_trial);
            end
            r_q <= {r_q[W-2:0], n_take};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

// File: rtl/core/windowed_motion_variance.sv
// Top level: sequencer, window state, configuration port and result register.
//
//  Channel    Direction  Transaction carries
//  i_sample   in         accel_x, accel_y, accel_z (signed mg)
//  o_result   out        latest_magnitude, mean_magnitude, magnitude_variance, motion
//  APB        in/out     motion_threshold at byte address 0
//
// Each accepted sample runs through LOAD, SQUARE, SUM, ROOT, UPDATE, DIVSTART, DIV, VAR and
// OUT before the next acceptance. The serial squarers, the square root and the mean divide
// followed by squaring the mean set the time per sample; the mean-square divider, 37 bits
// wide at a window depth of 32, runs alongside and finishes first.
// One sample is in flight at a time; a new one is taken as soon as the previous result sits
// in the output register, even if it is still stalled there.
// Reset is synchronous and active low; the ring holds no valid bits and needs no sweep.
module windowed_motion_variance #(
    parameter int unsigned WINDOW_DEPTH = wmv_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    wmv_stream_if.sink                       i_sample,
    wmv_stream_if.source                     o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wmv_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [wmv_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [wmv_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import wmv_pkg::*;

    localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int unsigned SUM_W  = MAG_W + SLOT_W;
    localparam int unsigned SQS_W  = MAG2_W + SLOT_W;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_LOAD     = 10'b00_0000_0010,
        S_SQUARE   = 10'b00_0000_0100,
        S_SUM      = 10'b00_0000_1000,
        S_ROOT     = 10'b00_0001_0000,
        S_UPDATE   = 10'b00_0010_0000,
        S_DIVSTART = 10'b00_0100_0000,
        S_DIV      = 10'b00_1000_0000,
        S_VAR      = 10'b01_0000_0000,
        S_OUT      = 10'b10_0000_0000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [THR_W-1:0]    r_threshold;
    logic [CNT_W-1:0]    r_fill;
    logic [SLOT_W-1:0]   r_slot;
    logic [SUM_W-1:0]    r_mag_sum;
    logic [SQS_W-1:0]    r_sq_sum;
    logic [MAG_W-1:0]    r_abs_x;
    logic [MAG_W-1:0]    r_abs_y;
    logic [MAG_W-1:0]    r_abs_z;
    logic [MAG2_W-1:0]   r_mag2;
    logic [MAG2_W-1:0]   r_mag_sq;
    logic [VAR_W-1:0]    r_var;
    logic                r_q_done;
    logic                r_m2_done;
    logic                r_out_valid;
    t_result             r_result;

    logic                accept;
    logic                cfg_write;
    logic                full;
    logic [MAG_W-1:0]    ring_rdata;
    t_unit_ctl           mul_x_ctl;
    t_unit_ctl           mul_y_ctl;
    t_unit_ctl           mul_z_ctl;
    t_unit_ctl           mul_s_ctl;
    t_unit_ctl           root_ctl;
    t_unit_ctl           mdiv_ctl;
    t_unit_ctl           qdiv_ctl;
    logic [MAG2_W-1:0]   prod_x;
    logic [MAG2_W-1:0]   prod_y;
    logic [MAG2_W-1:0]   prod_z;
    logic [MAG2_W-1:0]   prod_s;
    logic [MAG_W-1:0]    mul_s_op;
    logic [MAG_W-1:0]    root;
    logic [MAG_W+1:0]    root_rem;
    logic [SUM_W-1:0]    mean_q;
    logic [SQS_W-1:0]    meansq_q;
    logic [MAG2_W+1:0]   n_mag2;
    logic [SQS_W-1:0]    n_var_diff;
    logic                out_load;

    // Handshakes.
    assign accept           = i_sample.valid && i_sample.ready;
    assign i_sample.ready   = (r_state == S_IDLE);
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_result;
    assign out_load         = (r_state == S_OUT) && (!r_out_valid || o_result.ready);

    // Configuration port: a single threshold register, no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_MOTION_THRESHOLD)
                       ? CFG_DATA_W'(r_threshold) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (cfg_write &&
                     paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_MOTION_THRESHOLD) begin
            r_threshold <= THR_W'(pwdata);
        end
    end

    // Ring of the last magnitudes; the oldest entry is read at the write slot.
    wmv_ram #(
        .WIDTH (MAG_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_UPDATE),
        .i_waddr (r_slot),
        .i_wdata (root),
        .i_raddr (r_slot),
        .o_rdata (ring_rdata)
    );

    // Axis squares, and the oldest magnitude squared, all in the same serial pass.
    assign mul_x_ctl.start = (r_state == S_LOAD);
    assign mul_y_ctl.start = (r_state == S_LOAD);
    assign mul_z_ctl.start = (r_state == S_LOAD);

    wmv_smul #(.W(MAG_W)) u_mul_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (mul_x_ctl.start),
        .i_a (r_abs_x), .i_b (r_abs_x), .o_done (mul_x_ctl.done), .o_product (prod_x)
    );
    wmv_smul #(.W(MAG_W)) u_mul_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (mul_y_ctl.start),
        .i_a (r_abs_y), .i_b (r_abs_y), .o_done (mul_y_ctl.done), .o_product (prod_y)
    );
    wmv_smul #(.W(MAG_W)) u_mul_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (mul_z_ctl.start),
        .i_a (r_abs_z), .i_b (r_abs_z), .o_done (mul_z_ctl.done), .o_product (prod_z)
    );

    // Shared squarer: oldest magnitude first, the mean later on.
    assign mul_s_ctl.start = (r_state == S_LOAD) || mdiv_ctl.done;
    assign mul_s_op        = (r_state == S_LOAD) ? ring_rdata : mean_q[MAG_W-1:0];

    wmv_smul #(.W(MAG_W)) u_mul_s (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (mul_s_ctl.start),
        .i_a (mul_s_op), .i_b (mul_s_op), .o_done (mul_s_ctl.done), .o_product (prod_s)
    );

    // Floor square root of the squared magnitude.
    assign root_ctl.start = (r_state == S_SUM);

    wmv_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_ctl.start),
        .i_value (r_mag2),
        .o_done  (root_ctl.done),
        .o_root  (root),
        .o_rem   (root_rem)
    );

    // Mean and mean square over the fill count.
    assign mdiv_ctl.start = (r_state == S_DIVSTART);
    assign qdiv_ctl.start = (r_state == S_DIVSTART);

    wmv_sdiv #(.W(SUM_W), .D(CNT_W)) u_div_mean (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (mdiv_ctl.start),
        .i_dividend (r_mag_sum), .i_divisor (r_fill),
        .o_done (mdiv_ctl.done), .o_quotient (mean_q)
    );
    wmv_sdiv #(.W(SQS_W), .D(CNT_W)) u_div_msq (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (qdiv_ctl.start),
        .i_dividend (r_sq_sum), .i_divisor (r_fill),
        .o_done (qdiv_ctl.done), .o_quotient (meansq_q)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (accept) n_state = S_LOAD;
            S_LOAD:     n_state = S_SQUARE;
            S_SQUARE: begin
                if (mul_x_ctl.done && mul_y_ctl.done && mul_z_ctl.done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM:      n_state = S_ROOT;
            S_ROOT:     if (root_ctl.done) n_state = S_UPDATE;
            S_UPDATE:   n_state = S_DIVSTART;
            S_DIVSTART: n_state = S_DIV;
            S_DIV: begin
                if ((r_q_done || qdiv_ctl.done) && (r_m2_done || mul_s_ctl.done)) begin
                    n_state = S_VAR;
                end
            end
            S_VAR:      n_state = S_OUT;
            S_OUT:      if (out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window state: the oldest entry leaves the sums once the window is full.
    assign full = (r_fill == CNT_W'(WINDOW_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_slot    <= '0;
            r_mag_sum <= '0;
            r_sq_sum  <= '0;
        end else if (r_state == S_UPDATE) begin
            r_mag_sum <= r_mag_sum + SUM_W'(root) - (full ? SUM_W'(ring_rdata) : '0);
            r_sq_sum  <= r_sq_sum + SQS_W'(r_mag_sq) - (full ? SQS_W'(prod_s) : '0);
            if (!full) begin
                r_fill <= r_fill + 1'b1;
            end
            if (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) begin
                r_slot <= '0;
            end else begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    // Completion flags of the two parallel tails of the division step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_done  <= 1'b0;
            r_m2_done <= 1'b0;
        end else if (r_state == S_DIVSTART) begin
            r_q_done  <= 1'b0;
            r_m2_done <= 1'b0;
        end else if (r_state == S_DIV) begin
            if (qdiv_ctl.done) begin
                r_q_done <= 1'b1;
            end
            if (mul_s_ctl.done) begin
                r_m2_done <= 1'b1;
            end
        end
    end

    // Sample datapath registers.
    assign n_mag2     = (MAG2_W + 2)'(prod_x) + (MAG2_W + 2)'(prod_y) + (MAG2_W + 2)'(prod_z);
    assign n_var_diff = meansq_q - SQS_W'(prod_s);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_abs_x <= i_sample.payload.accel_x[AXIS_W-1]
                       ? MAG_W'(-i_sample.payload.accel_x) : MAG_W'(i_sample.payload.accel_x);
            r_abs_y <= i_sample.payload.accel_y[AXIS_W-1]
                       ? MAG_W'(-i_sample.payload.accel_y) : MAG_W'(i_sample.payload.accel_y);
            r_abs_z <= i_sample.payload.accel_z[AXIS_W-1]
                       ? MAG_W'(-i_sample.payload.accel_z) : MAG_W'(i_sample.payload.accel_z);
        end
        if (r_state == S_SQUARE && mul_x_ctl.done && mul_y_ctl.done && mul_z_ctl.done) begin
            r_mag2 <= n_mag2[MAG2_W-1:0];
        end
        // The root's remainder gives the magnitude squared without another multiply.
        if (r_state == S_ROOT && root_ctl.done) begin
            r_mag_sq <= r_mag2 - MAG2_W'(root_rem);
        end
        if (r_state == S_VAR) begin
            r_var <= (meansq_q > SQS_W'(prod_s)) ? n_var_diff[VAR_W-1:0] : '0;
        end
    end

    // Output register: parts the result side from the sample side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_result.latest_magnitude   <= root;
            r_result.mean_magnitude     <= mean_q[MAG_W-1:0];
            r_result.magnitude_variance <= r_var;
            r_result.motion             <= (r_var > r_threshold);
        end
    end

    // The fill count never passes the window depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    // Until the window is full the write slot tracks the fill count.
    a_slot_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill < CNT_W'(WINDOW_DEPTH)) |-> (CNT_W'(r_slot) == r_fill))
        else $error("write slot out of step with fill count");

    // An empty window has empty sums.
    a_empty_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_mag_sum == '0 && r_sq_sum == '0))
        else $error("non-zero sums with an empty window");

    // After a result load the sequencer is back in idle with the result valid.
    a_load_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_state == S_IDLE && r_out_valid))
        else $error("result load did not return to idle");

endmodule
